@@ hdl/pclb_pkg.sv @@
// ----------------------------------------------------------------------------
// pclb_pkg
// Shared types and fixed field widths for the particle cell list binner.
// ----------------------------------------------------------------------------
package pclb_pkg;

  // Input item fields
  localparam int PID_W      = 10;
  localparam int POS_W      = 17;
  localparam int IN_DATA_W  = 48;   // 44 bits of fields, padded to bytes

  // Result item fields
  localparam int CELL_W     = 6;
  localparam int ACT_W      = 2;
  localparam int CNT_W      = 11;
  localparam int OUT_DATA_W = 40;   // 35 bits of fields, padded to bytes

  typedef enum logic [ACT_W-1:0] {
    ACT_KEEP   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_MOVE   = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_MC,
    ST_MO,
    ST_UR,
    ST_UW,
    ST_RDC,
    ST_APP,
    ST_FIN,
    ST_DONE
  } st_t;

  // Per-particle placement word
  typedef struct packed {
    logic              placed;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
  } part_info_t;

endpackage

@@ hdl/particle_cell_list_binner_unit.sv @@
// ----------------------------------------------------------------------------
// particle_cell_list_binner_unit
// Each item runs ST_MX, ST_MY, ST_MC, ST_MO, then ST_UR and ST_UW to unlink a
// moved particle or ST_RDC otherwise, then ST_APP, ST_FIN for an insertion or
// move, and ST_DONE (one shared constant multiplier and tables with one read
// and one write port set the steps). The next item is taken while a result
// waits in the output register; ST_DONE holds until that register can take it.
// Reset: a clearing pass over max(MAX_PARTICLES, GRID_SIDE^2) entries (1600 by
// default) empties the cell and placement tables before in_tready rises.
// ----------------------------------------------------------------------------
module particle_cell_list_binner_unit #(
  parameter int GRID_SIDE     = 40,
  parameter int MAX_PARTICLES = 1024,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // particle_id[9:0], pos_x[26:10], pos_y[43:27]
  input  logic [pclb_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cell_x[5:0], cell_y[11:6], old_cell_x[17:12], old_cell_y[23:18],
  // member_count[34:24]
  output logic [pclb_pkg::OUT_DATA_W-1:0]  out_tdata,
  // action[1:0]
  output logic [pclb_pkg::ACT_W-1:0]       out_tuser
);

  localparam int PW      = pclb_pkg::POS_W;
  localparam int CW      = pclb_pkg::CELL_W;
  localparam int IDW     = pclb_pkg::PID_W;
  localparam int NCELLS  = GRID_SIDE * GRID_SIDE;
  localparam int PID_AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int LINK_W  = $clog2(MAX_PARTICLES + 1);
  localparam int CELL_AW = $clog2(NCELLS);
  localparam int GB_W    = $clog2(GRID_SIDE + 1);
  localparam int MUL_W   = PW + GB_W + 1;
  localparam int CLR_N   = (MAX_PARTICLES > NCELLS) ? MAX_PARTICLES : NCELLS;
  localparam int CLR_W   = $clog2(CLR_N);
  localparam int CMP_W   = (LINK_W > IDW) ? LINK_W : IDW;
  localparam int OPAD_W  = pclb_pkg::OUT_DATA_W - 4 * CW - pclb_pkg::CNT_W;

  localparam logic [LINK_W-1:0] NIL_C      = LINK_W'(MAX_PARTICLES);
  localparam logic [CLR_W:0]    CLR_PART_C = (CLR_W + 1)'(MAX_PARTICLES);
  localparam logic [CLR_W:0]    CLR_CELL_C = (CLR_W + 1)'(NCELLS);
  localparam logic [CLR_W-1:0]  CLR_LAST_C = CLR_W'(CLR_N - 1);

  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
    logic [LINK_W-1:0] cnt;
  } cell_ent_t;

  localparam cell_ent_t CELL_EMPTY_C = '{head: NIL_C, tail: NIL_C, cnt: '0};

  // Scale by GRID_SIDE already done; drop the fraction and clamp the top edge.
  function automatic logic [CW-1:0] to_cell(input logic [MUL_W-1:0] v);
    logic [MUL_W-1:0] q;
    q = v >> POS_FRAC_BITS;
    if (q >= MUL_W'(GRID_SIDE)) begin
      to_cell = CW'(GRID_SIDE - 1);
    end else begin
      to_cell = CW'(q);
    end
  endfunction

  // ---------------------------------------------------------------- storage
  pclb_pkg::part_info_t info_mem [MAX_PARTICLES];
  logic [LINK_W-1:0]    prev_mem [MAX_PARTICLES];
  logic [LINK_W-1:0]    next_mem [MAX_PARTICLES];
  cell_ent_t            cell_mem [NCELLS];

  pclb_pkg::part_info_t info_rd_r, info_wd;
  logic [LINK_W-1:0]    prev_rd_r, next_rd_r, prev_wd, next_wd;
  cell_ent_t            cell_rd_r, cell_wd;
  logic                 info_we, prev_we, next_we, cell_we;
  logic [PID_AW-1:0]    info_wa, prev_wa, next_wa;
  logic [CELL_AW-1:0]   cell_wa, cell_ra;

  // ---------------------------------------------------------------- registers
  pclb_pkg::st_t        state_r, state_nxt;
  logic [CLR_W-1:0]     clr_r, clr_nxt;
  logic [IDW-1:0]       p_r;
  logic [PW-1:0]        px_r, py_r;
  logic [MUL_W-1:0]     mul_r, mul_nxt;
  logic                 mul_en;
  logic [PW-1:0]        mul_a;
  logic [CW-1:0]        mul_c;
  logic [CW-1:0]        cx_r, cx_nxt, cy_r, cy_nxt, ox_r, ox_nxt, oy_r, oy_nxt;
  logic [CELL_AW-1:0]   cell_r, cell_nxt;
  pclb_pkg::action_t    act_r, act_nxt;
  logic [LINK_W-1:0]    cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [CW-1:0]        out_cx_r, out_cy_r, out_ox_r, out_oy_r;
  pclb_pkg::action_t    out_act_r;
  logic [LINK_W-1:0]    out_cnt_r;

  logic                 in_xfer, in_range, moved;
  logic [PID_AW-1:0]    pid_a;
  logic [LINK_W-1:0]    p_link;
  logic [CW-1:0]        clamp_v;

  assign in_xfer  = in_tvalid && in_tready;
  assign pid_a    = PID_AW'(p_r);
  assign p_link   = LINK_W'(p_r);
  assign in_range = CMP_W'(p_r) < CMP_W'(MAX_PARTICLES);
  assign clamp_v  = to_cell(mul_r);
  assign moved    = in_range && info_rd_r.placed &&
                    ((info_rd_r.cx != cx_r) || (info_rd_r.cy != cy_r));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pclb_pkg::ST_CLR:  if (clr_r == CLR_LAST_C) state_nxt = pclb_pkg::ST_IDLE;
      pclb_pkg::ST_IDLE: if (in_tvalid) state_nxt = pclb_pkg::ST_MX;
      pclb_pkg::ST_MX:   state_nxt = pclb_pkg::ST_MY;
      pclb_pkg::ST_MY:   state_nxt = pclb_pkg::ST_MC;
      pclb_pkg::ST_MC:   state_nxt = pclb_pkg::ST_MO;
      pclb_pkg::ST_MO:   state_nxt = moved ? pclb_pkg::ST_UR : pclb_pkg::ST_RDC;
      pclb_pkg::ST_UR:   state_nxt = pclb_pkg::ST_UW;
      pclb_pkg::ST_UW:   state_nxt = pclb_pkg::ST_APP;
      pclb_pkg::ST_RDC:  state_nxt = pclb_pkg::ST_APP;
      pclb_pkg::ST_APP: begin
        state_nxt = (act_r != pclb_pkg::ACT_KEEP) ? pclb_pkg::ST_FIN : pclb_pkg::ST_DONE;
      end
      pclb_pkg::ST_FIN:  state_nxt = pclb_pkg::ST_DONE;
      pclb_pkg::ST_DONE: if (!out_valid_r || out_tready) state_nxt = pclb_pkg::ST_IDLE;
      default:           state_nxt = pclb_pkg::ST_CLR;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    clr_nxt  = clr_r;
    mul_en   = 1'b0;
    mul_a    = px_r;
    mul_c    = '0;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    cell_nxt = cell_r;
    act_nxt  = act_r;
    cnt_nxt  = cnt_r;
    out_load = 1'b0;
    cell_ra  = cell_r;
    info_we  = 1'b0;
    info_wa  = pid_a;
    info_wd  = '{placed: 1'b1, cx: cx_r, cy: cy_r};
    prev_we  = 1'b0;
    prev_wa  = pid_a;
    prev_wd  = NIL_C;
    next_we  = 1'b0;
    next_wa  = pid_a;
    next_wd  = NIL_C;
    cell_we  = 1'b0;
    cell_wa  = cell_r;
    cell_wd  = cell_rd_r;

    unique case (state_r)
      pclb_pkg::ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        info_we = ({1'b0, clr_r} < CLR_PART_C);
        info_wa = clr_r[PID_AW-1:0];
        info_wd = '0;
        cell_we = ({1'b0, clr_r} < CLR_CELL_C);
        cell_wa = clr_r[CELL_AW-1:0];
        cell_wd = CELL_EMPTY_C;
      end
      pclb_pkg::ST_MX: begin
        mul_en = 1'b1;
        mul_a  = px_r;
      end
      pclb_pkg::ST_MY: begin
        cx_nxt = clamp_v;
        mul_en = 1'b1;
        mul_a  = py_r;
      end
      pclb_pkg::ST_MC: begin
        cy_nxt = clamp_v;
        mul_en = 1'b1;
        mul_a  = PW'(cx_r);
        mul_c  = clamp_v;
      end
      pclb_pkg::ST_MO: begin
        // mul_r holds the new cell index; start the old cell index
        cell_nxt = mul_r[CELL_AW-1:0];
        mul_en   = 1'b1;
        mul_a    = PW'(info_rd_r.cx);
        mul_c    = info_rd_r.cy;
        ox_nxt   = moved ? info_rd_r.cx : cx_r;
        oy_nxt   = moved ? info_rd_r.cy : cy_r;
        if (!in_range) begin
          act_nxt = pclb_pkg::ACT_KEEP;
        end else if (!info_rd_r.placed) begin
          act_nxt = pclb_pkg::ACT_INSERT;
        end else if (moved) begin
          act_nxt = pclb_pkg::ACT_MOVE;
        end else begin
          act_nxt = pclb_pkg::ACT_KEEP;
        end
      end
      pclb_pkg::ST_UR: begin
        cell_ra = mul_r[CELL_AW-1:0];
      end
      pclb_pkg::ST_UW: begin
        // unlink from the old cell; prev_rd_r/next_rd_r are this particle's links
        cell_wa = mul_r[CELL_AW-1:0];
        cell_we = 1'b1;
        if (prev_rd_r >= NIL_C) begin
          cell_wd.head = next_rd_r;
        end else begin
          next_we = 1'b1;
          next_wa = prev_rd_r[PID_AW-1:0];
          next_wd = next_rd_r;
        end
        if (next_rd_r >= NIL_C) begin
          cell_wd.tail = prev_rd_r;
        end else begin
          prev_we = 1'b1;
          prev_wa = next_rd_r[PID_AW-1:0];
          prev_wd = prev_rd_r;
        end
        if (cell_rd_r.cnt != '0) cell_wd.cnt = cell_rd_r.cnt - 1'b1;
      end
      pclb_pkg::ST_APP: begin
        cnt_nxt = cell_rd_r.cnt;
        if (act_r != pclb_pkg::ACT_KEEP) begin
          cnt_nxt      = cell_rd_r.cnt + 1'b1;
          prev_we      = 1'b1;
          prev_wd      = cell_rd_r.tail;
          cell_we      = 1'b1;
          cell_wd.tail = p_link;
          cell_wd.cnt  = cell_rd_r.cnt + 1'b1;
          if (cell_rd_r.tail >= NIL_C) begin
            cell_wd.head = p_link;
          end else begin
            next_we = 1'b1;
            next_wa = cell_rd_r.tail[PID_AW-1:0];
            next_wd = p_link;
          end
        end
      end
      pclb_pkg::ST_FIN: begin
        next_we = 1'b1;
        info_we = 1'b1;
      end
      pclb_pkg::ST_DONE: begin
        out_load = !out_valid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  // shared constant multiplier: a * GRID_SIDE + c
  assign mul_nxt = MUL_W'(mul_a) * MUL_W'(GRID_SIDE) + MUL_W'(mul_c);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pclb_pkg::ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      act_r       <= pclb_pkg::ACT_KEEP;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      act_r       <= act_nxt;
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_r  <= in_tdata[IDW-1:0];
      px_r <= in_tdata[IDW +: PW];
      py_r <= in_tdata[IDW + PW +: PW];
    end
    if (mul_en) mul_r <= mul_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    cell_r <= cell_nxt;
    cnt_r  <= cnt_nxt;
    if (out_load) begin
      out_cx_r  <= cx_r;
      out_cy_r  <= cy_r;
      out_ox_r  <= ox_r;
      out_oy_r  <= oy_r;
      out_act_r <= act_r;
      out_cnt_r <= cnt_r;
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    info_rd_r <= info_mem[pid_a];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd_r <= prev_mem[pid_a];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_r <= next_mem[pid_a];
  end

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    cell_rd_r <= cell_mem[cell_ra];
  end

  // ---------------------------------------------------------------- ports
  assign in_tready  = (state_r == pclb_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = {{OPAD_W{1'b0}}, pclb_pkg::CNT_W'(out_cnt_r),
                       out_oy_r, out_ox_r, out_cy_r, out_cx_r};

  // ---------------------------------------------------------------- checks
  a_keep_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_act_r == pclb_pkg::ACT_KEEP) |->
      (out_ox_r == out_cx_r) && (out_oy_r == out_cy_r))
    else $error("unchanged result reports a different old cell");

  a_update_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_act_r != pclb_pkg::ACT_KEEP) |-> (out_cnt_r != '0))
    else $error("inserted or moved particle left an empty cell");

  a_fin_after_app: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pclb_pkg::ST_FIN) |-> ($past(state_r) == pclb_pkg::ST_APP) &&
      ($past(act_r) != pclb_pkg::ACT_KEEP))
    else $error("placement written without an append");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pclb_pkg::ST_CLR) |-> !out_valid_r && !in_tready)
    else $error("traffic during clearing pass");

endmodule

@@ test/particle_cell_list_binner_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_cell_list_binner_unit_test
// Streams particle positions into the binner and checks every result against
// a cycle-free model of the cell grid, kept as per-cell linked lists.
// Directed items hit the grid edges, each action and unlinking from the head,
// middle and tail of a list. Random items follow, with a small set of
// recurring particles crowded into a few cells. Both sides stall at random,
// and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module particle_cell_list_binner_unit_test;

  localparam int GRID       = 40;
  localparam int NCELL      = GRID * GRID;
  localparam int NPART      = 1024;
  localparam int FRAC       = 16;
  localparam int NULL_LINK  = NPART;
  localparam int POS_MAX    = 131071;
  localparam int RAND_ITEMS = 1850;
  localparam int POOL_SIZE  = 48;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 400;
  localparam int CYCLE_CAP  = 400000;
  localparam int IN_PAD_W   = pclb_pkg::IN_DATA_W - pclb_pkg::PID_W - 2 * pclb_pkg::POS_W;

  typedef struct {
    logic [pclb_pkg::PID_W-1:0] pid;
    logic [pclb_pkg::POS_W-1:0] px;
    logic [pclb_pkg::POS_W-1:0] py;
  } bin_req_t;

  typedef struct packed {
    logic [pclb_pkg::CELL_W-1:0] cell_x;
    logic [pclb_pkg::CELL_W-1:0] cell_y;
    logic [pclb_pkg::CELL_W-1:0] old_x;
    logic [pclb_pkg::CELL_W-1:0] old_y;
    logic [pclb_pkg::CNT_W-1:0]  count;
    pclb_pkg::action_t           act;
  } bin_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pclb_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pclb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [pclb_pkg::ACT_W-1:0]      out_tuser;

  // grid model
  logic       placed    [0:NPART-1];
  int         part_cx   [0:NPART-1];
  int         part_cy   [0:NPART-1];
  int         link_prev [0:NPART-1];
  int         link_next [0:NPART-1];
  int         cell_head [0:NCELL-1];
  int         cell_tail [0:NCELL-1];
  int         cell_cnt  [0:NCELL-1];

  // stimulus bookkeeping
  bit         gen_seen [0:NPART-1];
  int         gen_x    [0:NPART-1];
  int         gen_y    [0:NPART-1];

  bin_req_t    pending[$];
  bin_result_t expected_bins[$];

  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int mismatches   = 0;
  int n_insert     = 0;
  int n_move       = 0;
  int n_keep       = 0;
  int cycle_cnt    = 0;
  int hold_left    = 0;
  bit hold_armed   = 1'b1;
  bit steady;

  particle_cell_list_binner_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side through this window
  assign steady = (accepted_cnt >= 900) && (accepted_cnt < 1250);

  function automatic int pos_to_cell(input logic [pclb_pkg::POS_W-1:0] pos);
    int c;
    c = (int'(pos) * GRID) >> FRAC;
    return (c >= GRID) ? GRID - 1 : c;
  endfunction

  function automatic bin_result_t bin_particle(input logic [pclb_pkg::PID_W-1:0] pid,
                                               input logic [pclb_pkg::POS_W-1:0] px,
                                               input logic [pclb_pkg::POS_W-1:0] py);
    bin_result_t res;
    int cx, cy, cidx, oidx, pv, nx, tl;
    cx   = pos_to_cell(px);
    cy   = pos_to_cell(py);
    cidx = cx * GRID + cy;
    res.cell_x = pclb_pkg::CELL_W'(cx);
    res.cell_y = pclb_pkg::CELL_W'(cy);
    res.old_x  = pclb_pkg::CELL_W'(cx);
    res.old_y  = pclb_pkg::CELL_W'(cy);
    res.act    = pclb_pkg::ACT_KEEP;
    if (!placed[pid] || part_cx[pid] != cx || part_cy[pid] != cy) begin
      if (placed[pid]) begin
        res.old_x = pclb_pkg::CELL_W'(part_cx[pid]);
        res.old_y = pclb_pkg::CELL_W'(part_cy[pid]);
        res.act   = pclb_pkg::ACT_MOVE;
        oidx = part_cx[pid] * GRID + part_cy[pid];
        pv = link_prev[pid];
        nx = link_next[pid];
        if (pv == NULL_LINK) cell_head[oidx] = nx;
        else link_next[pv] = nx;
        if (nx == NULL_LINK) cell_tail[oidx] = pv;
        else link_prev[nx] = pv;
        if (cell_cnt[oidx] != 0) cell_cnt[oidx]--;
        n_move++;
      end else begin
        res.act = pclb_pkg::ACT_INSERT;
        n_insert++;
      end
      // append at the tail of the new cell
      tl = cell_tail[cidx];
      link_prev[pid] = tl;
      link_next[pid] = NULL_LINK;
      if (tl == NULL_LINK) cell_head[cidx] = int'(pid);
      else link_next[tl] = int'(pid);
      cell_tail[cidx] = int'(pid);
      cell_cnt[cidx]++;
      placed[pid]  = 1'b1;
      part_cx[pid] = cx;
      part_cy[pid] = cy;
    end else begin
      n_keep++;
    end
    res.count = pclb_pkg::CNT_W'(cell_cnt[cidx]);
    return res;
  endfunction

  task automatic add_req(input int pid, input int px, input int py);
    bin_req_t r;
    r.pid = pclb_pkg::PID_W'(pid);
    r.px  = pclb_pkg::POS_W'(px);
    r.py  = pclb_pkg::POS_W'(py);
    pending.insert(pending.size(), r);
    gen_seen[pid] = 1'b1;
    gen_x[pid]    = px;
    gen_y[pid]    = py;
  endtask

  function automatic int nudge(input int v);
    int w;
    w = v + int'($urandom_range(0, 400)) - 200;
    if (w < 0) w = 0;
    if (w > POS_MAX) w = POS_MAX;
    return w;
  endfunction

  task automatic check_field(input string what, input logic [pclb_pkg::CNT_W-1:0] exp_v,
                             input logic [pclb_pkg::CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endtask

  // input driver; the model advances on each accepted transfer
  always @(posedge clk) begin : drive_proc
    bin_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_bins.insert(expected_bins.size(),
                             bin_particle(in_tdata[pclb_pkg::PID_W-1:0],
                                          in_tdata[pclb_pkg::PID_W +: pclb_pkg::POS_W],
                                          in_tdata[pclb_pkg::PID_W+pclb_pkg::POS_W +:
                                                   pclb_pkg::POS_W]));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
          req = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{IN_PAD_W{1'b0}}, req.py, req.px, req.pid};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long output hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && accepted_cnt >= HOLD_AT) begin
      hold_left  <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 25);
  end

  // result monitor
  always @(posedge clk) begin : watch_proc
    bin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bins.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, actual data %h action %0d",
                 $time, out_tdata, out_tuser);
      end else begin
        want = expected_bins.pop_front();
        check_field("cell_x", pclb_pkg::CNT_W'(want.cell_x),
                    pclb_pkg::CNT_W'(out_tdata[5:0]));
        check_field("cell_y", pclb_pkg::CNT_W'(want.cell_y),
                    pclb_pkg::CNT_W'(out_tdata[11:6]));
        check_field("old_cell_x", pclb_pkg::CNT_W'(want.old_x),
                    pclb_pkg::CNT_W'(out_tdata[17:12]));
        check_field("old_cell_y", pclb_pkg::CNT_W'(want.old_y),
                    pclb_pkg::CNT_W'(out_tdata[23:18]));
        check_field("member_count", want.count, out_tdata[34:24]);
        check_field("action", pclb_pkg::CNT_W'(want.act), pclb_pkg::CNT_W'(out_tuser));
        checked_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("%0t: timeout with %0d items pending, %0d results outstanding",
               $time, pending.size(), expected_bins.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stim_proc
    int pool [0:POOL_SIZE-1];
    int n, r, pid, px, py;
    for (int k = 0; k < NPART; k++) begin
      placed[k]    = 1'b0;
      part_cx[k]   = 0;
      part_cy[k]   = 0;
      link_prev[k] = NULL_LINK;
      link_next[k] = NULL_LINK;
      gen_seen[k]  = 1'b0;
      gen_x[k]     = 0;
      gen_y[k]     = 0;
    end
    for (int k = 0; k < NCELL; k++) begin
      cell_head[k] = NULL_LINK;
      cell_tail[k] = NULL_LINK;
      cell_cnt[k]  = 0;
    end

    // fill cell (0,0) with four members, then pull them out of the
    // middle, the head and the tail of its list
    add_req(0, 0, 0);
    add_req(1, 1638, 1638);
    add_req(2, 1000, 500);
    add_req(3, 0, 1638);
    add_req(1, 1639, 0);
    add_req(0, 0, 1639);
    add_req(3, 65535, 65535);
    add_req(2, 5, 5);
    add_req(2, 1639, 1639);           // sole member leaves, cell goes empty
    // top edge and beyond clamp to the last cell
    add_req(1023, POS_MAX, POS_MAX);
    add_req(1023, 65536, 65536);
    add_req(1023, 65535, 0);
    add_req(512, 65536, POS_MAX);
    add_req(3, 0, 0);
    add_req(682, 87381, 43690);
    add_req(341, 43690, 87381);
    add_req(1023, 0, 65535);
    add_req(0, 1639, 0);
    add_req(1, 32768, 32768);
    add_req(0, 32768, 32768);
    add_req(1, 32767, 32768);
    add_req(0, 1639, 1);

    for (int k = 0; k < POOL_SIZE; k++) pool[k] = $urandom_range(0, NPART - 1);
    for (n = 0; n < RAND_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 70) pid = pool[$urandom_range(0, POOL_SIZE - 1)];
      else pid = $urandom_range(0, NPART - 1);
      r = $urandom_range(0, 99);
      if (gen_seen[pid] && r < 45) begin
        px = nudge(gen_x[pid]);
        py = nudge(gen_y[pid]);
      end else if (r < 75) begin
        // crowd a 3x3 block of cells so lists grow long
        px = $urandom_range(16384, 21298);
        py = $urandom_range(16384, 21298);
      end else if (r < 88) begin
        px = $urandom_range(0, 65536);
        py = $urandom_range(0, 65536);
      end else begin
        px = $urandom_range(0, 1) ? $urandom_range(65536, POS_MAX) : $urandom_range(0, 65535);
        py = $urandom_range(65536, POS_MAX);
      end
      add_req(pid, px, py);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid || expected_bins.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("binned %0d particle updates: %0d inserts, %0d moves, %0d unchanged",
             checked_cnt, n_insert, n_move, n_keep);
    $display("edges clamped, lists unlinked at head/middle/tail, output held %0d cycles",
             HOLD_LEN);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
